// ===== rtl/rbht_pkg.sv =====
// Shared types and constants for the relay bank hysteresis timer.
`default_nettype none

package rbht_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_EVAL  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_BIT   = 2'd2
  } kind_t;

  localparam int DEF_NUM_ACTORS   = 8;
  localparam int DEF_NUM_CHANNELS = 6;
  localparam int DEF_TIME_WIDTH   = 32;

  localparam int MAX_ACTORS   = 8;
  localparam int MAX_CHANNELS = 8;
  localparam int NUM_MEAS     = 5;
  localparam int PATTERN_W    = 8;
  localparam int TIME_IN_W    = 32;
  localparam int SAMPLE_W     = 16;
  localparam int HOUR_W       = 5;
  localparam int LIMIT_W      = 24;
  localparam int CHAN_SEL_W   = 3;
  localparam int CFG_INDEX_W  = 3;

  // Setup word layout.
  localparam int SETUP_W     = 54;
  localparam int SETUP_EN    = 0;
  localparam int SETUP_TIMED = 1;
  localparam int SETUP_INV   = 2;
  localparam int SETUP_CH_LO = 3;
  localparam int SETUP_LO_LO = 6;
  localparam int SETUP_HI_LO = 30;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Per-lane control strobes from the top level.
  typedef struct packed {
    logic cfg_write;
    logic eval;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rbht_lane.sv =====
// One actor lane: setup word, timer state and the next value of its relay bit.
`default_nettype none

module rbht_lane #(
  parameter int NUM_CHANNELS = rbht_pkg::DEF_NUM_CHANNELS,
  parameter int TIME_WIDTH   = rbht_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rbht_pkg::lane_ctl_t            ctl,
  input  wire logic [rbht_pkg::SETUP_W-1:0]   cfg_data,
  input  wire logic [TIME_WIDTH-1:0]          now,
  input  wire rbht_pkg::sample_t              chan_value [rbht_pkg::MAX_CHANNELS],
  input  wire logic                           bit_cur,
  output logic                                bit_next
);

  localparam int CMP_W = (TIME_WIDTH > rbht_pkg::LIMIT_W) ? TIME_WIDTH : rbht_pkg::LIMIT_W;
  localparam logic [rbht_pkg::CHAN_SEL_W-1:0] HOUR_CH =
    rbht_pkg::CHAN_SEL_W'(NUM_CHANNELS - 1);
  localparam logic [rbht_pkg::CHAN_SEL_W:0] CH_LIMIT =
    (rbht_pkg::CHAN_SEL_W + 1)'(NUM_CHANNELS);

  logic [rbht_pkg::SETUP_W-1:0] setup;
  logic                         running;
  logic [TIME_WIDTH-1:0]        on_since;
  logic [TIME_WIDTH-1:0]        off_since;

  logic                               running_next;
  logic                               load_on;
  logic                               load_off;
  logic                               enable;
  logic                               timed;
  logic                               inverted;
  logic [rbht_pkg::CHAN_SEL_W-1:0]    ch;
  logic [rbht_pkg::LIMIT_W-1:0]       low_u;
  logic [rbht_pkg::LIMIT_W-1:0]       high_u;
  logic signed [rbht_pkg::LIMIT_W-1:0] value_s;
  logic [TIME_WIDTH-1:0]              on_age;
  logic [TIME_WIDTH-1:0]              off_age;

  assign enable   = setup[rbht_pkg::SETUP_EN];
  assign timed    = setup[rbht_pkg::SETUP_TIMED];
  assign inverted = setup[rbht_pkg::SETUP_INV];
  assign ch       = setup[rbht_pkg::SETUP_CH_LO +: rbht_pkg::CHAN_SEL_W];
  assign low_u    = setup[rbht_pkg::SETUP_LO_LO +: rbht_pkg::LIMIT_W];
  assign high_u   = setup[rbht_pkg::SETUP_HI_LO +: rbht_pkg::LIMIT_W];

  // Sign-extend the selected channel; the hour channel holds a small positive value.
  assign value_s = rbht_pkg::LIMIT_W'(chan_value[ch]);
  assign on_age  = now - on_since;
  assign off_age = now - off_since;

  always_comb begin
    bit_next     = bit_cur;
    running_next = running;
    load_on      = 1'b0;
    load_off     = 1'b0;
    if (enable) begin
      if (!timed) begin
        if ({1'b0, ch} < CH_LIMIT) begin
          if (value_s >= $signed(high_u)) begin
            bit_next = inverted;
          end else if (value_s <= $signed(low_u)) begin
            bit_next = !inverted;
          end
        end
      end else if (running) begin
        if (ch == HOUR_CH) begin
          if (value_s >= $signed(low_u)) begin
            bit_next = 1'b0;
          end else if (value_s >= $signed(high_u)) begin
            bit_next = 1'b1;
          end
        end else if (CMP_W'(on_age) >= CMP_W'(high_u)) begin
          bit_next     = 1'b0;
          running_next = 1'b0;
          load_off     = 1'b1;
        end
      end else if (CMP_W'(off_age) >= CMP_W'(low_u)) begin
        bit_next     = 1'b1;
        running_next = 1'b1;
        load_on      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup     <= '0;
      running   <= 1'b0;
      on_since  <= '0;
      off_since <= '0;
    end else if (ctl.cfg_write) begin
      setup   <= cfg_data;
      running <= cfg_data[rbht_pkg::SETUP_EN];
    end else if (ctl.eval) begin
      running <= running_next;
      if (load_on) begin
        on_since <= now;
      end
      if (load_off) begin
        off_since <= now;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rbht_merge.sv =====
// Merge of the lane results and the direct writes into the next relay pattern.
`default_nettype none

module rbht_merge #(
  parameter int NUM_ACTORS = rbht_pkg::DEF_NUM_ACTORS
) (
  input  wire rbht_pkg::kind_t                 kind,
  input  wire logic [rbht_pkg::PATTERN_W-1:0]  pattern,
  input  wire logic [NUM_ACTORS-1:0]           lane_bits,
  input  wire logic [rbht_pkg::PATTERN_W-1:0]  write_value,
  input  wire logic [rbht_pkg::CHAN_SEL_W-1:0] bit_index,
  input  wire logic                            bit_value,
  output logic [rbht_pkg::PATTERN_W-1:0]       pattern_next
);

  always_comb begin
    pattern_next = pattern;
    case (kind)
      rbht_pkg::KIND_EVAL: begin
        pattern_next[NUM_ACTORS-1:0] = lane_bits;
      end
      rbht_pkg::KIND_WRITE: begin
        pattern_next = write_value;
      end
      rbht_pkg::KIND_BIT: begin
        pattern_next[bit_index] = bit_value;
      end
      default: begin
        pattern_next = pattern;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/relay_bank_hysteresis_timer.sv =====
// Top level of the relay bank hysteresis timer: lanes, merge and output register.
// The block drives a bank of eight relays. Each input transaction is one of three
// kinds: evaluate, which runs every enabled actor against its sensor channel or
// its on/off timer; write, which loads the whole relay pattern; and write-bit,
// which sets a single relay. Every input transaction yields exactly one output
// transaction carrying the relay pattern as it stands after that transaction.
// One lane per actor evaluates all actors in parallel, combinationally, and the
// merge stage folds the lane bits or the direct write into the pattern register.
// The result is valid on the cycle after acceptance, and a new input transaction
// can be taken every cycle while the receiver keeps up.
// The relay pattern register is also the output register, so when the receiver
// stalls the result holds and in_stall is raised until the result is taken.
// The user writes setup words through the cfg port only while the block is idle;
// the block does not enforce this. A setup write reloads that actor's running flag
// from its enable bit. Synchronous reset clears the pattern, all setup words, the
// running flags and the timer stamps, and drops out_valid.
`default_nettype none

module relay_bank_hysteresis_timer #(
  parameter int NUM_ACTORS   = rbht_pkg::DEF_NUM_ACTORS,
  parameter int NUM_CHANNELS = rbht_pkg::DEF_NUM_CHANNELS,
  parameter int TIME_WIDTH   = rbht_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_write,
  input  wire logic [rbht_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rbht_pkg::SETUP_W-1:0]     cfg_data,
  // Input channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       kind,
  input  wire logic [rbht_pkg::TIME_IN_W-1:0]   time_ms,
  input  wire logic signed [rbht_pkg::SAMPLE_W-1:0] measurement_0,
  input  wire logic signed [rbht_pkg::SAMPLE_W-1:0] measurement_1,
  input  wire logic signed [rbht_pkg::SAMPLE_W-1:0] measurement_2,
  input  wire logic signed [rbht_pkg::SAMPLE_W-1:0] measurement_3,
  input  wire logic signed [rbht_pkg::SAMPLE_W-1:0] measurement_4,
  input  wire logic [rbht_pkg::HOUR_W-1:0]      hour_now,
  input  wire logic [rbht_pkg::PATTERN_W-1:0]   write_value,
  input  wire logic [rbht_pkg::CHAN_SEL_W-1:0]  bit_index,
  input  wire logic                             bit_value,
  // Output channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rbht_pkg::PATTERN_W-1:0]        relay_bits
);

  logic                            accept;
  logic                            eval;
  rbht_pkg::kind_t                 kind_in;
  logic [rbht_pkg::PATTERN_W-1:0]  relay_pattern;
  logic [rbht_pkg::PATTERN_W-1:0]  relay_pattern_next;
  logic [NUM_ACTORS-1:0]           lane_bits;
  logic [TIME_WIDTH-1:0]           now;
  rbht_pkg::sample_t               meas [rbht_pkg::NUM_MEAS];
  rbht_pkg::sample_t               chan_value [rbht_pkg::MAX_CHANNELS];

  assign kind_in  = rbht_pkg::kind_t'(kind);
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign eval     = accept && (kind_in == rbht_pkg::KIND_EVAL);
  assign now      = time_ms[TIME_WIDTH-1:0];

  assign meas[0] = measurement_0;
  assign meas[1] = measurement_1;
  assign meas[2] = measurement_2;
  assign meas[3] = measurement_3;
  assign meas[4] = measurement_4;

  // Channel table: the last channel is the hour; channels without a sensor read zero.
  for (genvar c = 0; c < rbht_pkg::MAX_CHANNELS; c++) begin : g_chan
    if (c == NUM_CHANNELS - 1) begin : g_hour
      assign chan_value[c] = rbht_pkg::SAMPLE_W'(hour_now);
    end else if (c < rbht_pkg::NUM_MEAS) begin : g_meas
      assign chan_value[c] = meas[c];
    end else begin : g_zero
      assign chan_value[c] = '0;
    end
  end

  for (genvar i = 0; i < NUM_ACTORS; i++) begin : g_lane
    rbht_pkg::lane_ctl_t ctl;

    assign ctl.cfg_write = cfg_write && (cfg_index == rbht_pkg::CFG_INDEX_W'(i));
    assign ctl.eval      = eval;

    rbht_lane #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_WIDTH   (TIME_WIDTH)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cfg_data   (cfg_data),
      .now        (now),
      .chan_value (chan_value),
      .bit_cur    (relay_pattern[i]),
      .bit_next   (lane_bits[i])
    );
  end

  rbht_merge #(
    .NUM_ACTORS (NUM_ACTORS)
  ) u_merge (
    .kind         (kind_in),
    .pattern      (relay_pattern),
    .lane_bits    (lane_bits),
    .write_value  (write_value),
    .bit_index    (bit_index),
    .bit_value    (bit_value),
    .pattern_next (relay_pattern_next)
  );

  // The pattern only changes on an accepted transaction, which cannot happen while
  // a result is held, so the pattern register doubles as the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_pattern <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        relay_pattern <= relay_pattern_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign relay_bits = relay_pattern;

endmodule

`default_nettype wire
